// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define CH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next-cycle check");

`endif

// ===== hdl/chull_pkg.sv =====
// ----------------------------------------------------------------------------
// chull_pkg
// Shared types and constants of the planar convex hull block.
// ----------------------------------------------------------------------------
package chull_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 32;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_RING  = 2'd2
    } hull_kind_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               set_end;
    } point_req_t;

    typedef struct packed {
        logic signed [31:0] hull_x;
        logic signed [31:0] hull_y;
        logic signed [31:0] hull_z;
        hull_kind_t         hull_kind;
        logic               capacity_hit;
        logic               run_end;
    } hull_res_t;

    // Control of the sorting chain: insert a point, or shift everything
    // one cell toward the head.
    typedef struct packed {
        logic ins;
        logic drain;
    } chain_ctl_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_SETUP,
        ST_FETCH,
        ST_CATCH,
        ST_TEST,
        ST_MUL,
        ST_DECIDE,
        ST_POP,
        ST_ORD,
        ST_OLOAD,
        ST_SHOW
    } scan_state_t;

endpackage

// ===== hdl/chull_cell.sv =====
// ----------------------------------------------------------------------------
// chull_cell
// One cell of the insertion sorting chain; holds a single point.
// ----------------------------------------------------------------------------
module chull_cell
    import chull_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chain_ctl_t           ctl,
    input  logic signed [CW-1:0] new_x,
    input  logic signed [CW-1:0] new_y,
    input  logic signed [CW-1:0] prev_x,
    input  logic signed [CW-1:0] prev_y,
    input  logic                 prev_valid,
    input  logic                 prev_less,
    input  logic signed [CW-1:0] next_x,
    input  logic signed [CW-1:0] next_y,
    input  logic                 next_valid,
    output logic signed [CW-1:0] pt_x,
    output logic signed [CW-1:0] pt_y,
    output logic                 valid,
    output logic                 less
);

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic                 valid_reg, valid_next;

    // The new point sorts strictly before the one held here.
    assign less = valid_reg &&
                  ((new_x < x_reg) || ((new_x == x_reg) && (new_y < y_reg)));

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        valid_next = valid_reg;
        if (ctl.drain)
        begin
            x_next     = next_x;
            y_next     = next_y;
            valid_next = next_valid;
        end
        else if (ctl.ins)
        begin
            if (prev_less)
            begin
                x_next     = prev_x;
                y_next     = prev_y;
                valid_next = 1'b1;
            end
            else if (prev_valid && (less || !valid_reg))
            begin
                x_next     = new_x;
                y_next     = new_y;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign pt_x  = x_reg;
    assign pt_y  = y_reg;
    assign valid = valid_reg;

endmodule

// ===== hdl/chull_chain.sv =====
// ----------------------------------------------------------------------------
// chull_chain
// Row of sorting cells; keeps the stored points ordered by x, then y.
// ----------------------------------------------------------------------------
module chull_chain
    import chull_pkg::*;
#(
    parameter  int MAX_POINTS = MAX_POINTS_DEF,
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int CW         = (COORD_BITS < 32) ? COORD_BITS : 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chain_ctl_t           ctl,
    input  logic signed [CW-1:0] new_x,
    input  logic signed [CW-1:0] new_y,
    output logic signed [CW-1:0] head_x,
    output logic signed [CW-1:0] head_y
);

    logic signed [CW-1:0] cx [MAX_POINTS];
    logic signed [CW-1:0] cy [MAX_POINTS];
    logic                 cv [MAX_POINTS];
    logic                 cl [MAX_POINTS];

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic signed [CW-1:0] px, py, nx, ny;
        logic                 pv, pl, nv;

        if (i == 0)
        begin : g_first
            assign px = '0;
            assign py = '0;
            assign pv = 1'b1;
            assign pl = 1'b0;
        end
        else
        begin : g_mid
            assign px = cx[i-1];
            assign py = cy[i-1];
            assign pv = cv[i-1];
            assign pl = cl[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_last
            assign nx = '0;
            assign ny = '0;
            assign nv = 1'b0;
        end
        else
        begin : g_inner
            assign nx = cx[i+1];
            assign ny = cy[i+1];
            assign nv = cv[i+1];
        end

        chull_cell #(
            .CW (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_x      (new_x),
            .new_y      (new_y),
            .prev_x     (px),
            .prev_y     (py),
            .prev_valid (pv),
            .prev_less  (pl),
            .next_x     (nx),
            .next_y     (ny),
            .next_valid (nv),
            .pt_x       (cx[i]),
            .pt_y       (cy[i]),
            .valid      (cv[i]),
            .less       (cl[i])
        );
    end

    assign head_x = cx[0];
    assign head_y = cy[0];

endmodule

// ===== hdl/chull_scan.sv =====
// ----------------------------------------------------------------------------
// chull_scan
// Drains the sorted chain, removes duplicates and runs the monotone chain
// hull with a point memory and a stack memory, then emits the vertices.
// ----------------------------------------------------------------------------
module chull_scan
    import chull_pkg::*;
#(
    parameter  int MAX_POINTS = MAX_POINTS_DEF,
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int CW         = (COORD_BITS < 32) ? COORD_BITS : 32,
    localparam int CNTW       = $clog2(MAX_POINTS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNTW-1:0]      stored_cnt,
    input  logic signed [31:0]   lowest_z,
    input  logic                 overflow,
    input  logic signed [CW-1:0] head_x,
    input  logic signed [CW-1:0] head_y,
    output logic                 drain,
    output logic                 busy,
    output logic                 done,
    output logic                 hull_valid,
    input  logic                 hull_stall,
    output hull_res_t            hull
);

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int SD  = 2 * MAX_POINTS;
    localparam int SAW = $clog2(SD);
    localparam int KW  = $clog2(SD + 1);
    localparam int PW  = 2 * CW + 2;

    logic [2*CW-1:0] pmem [MAX_POINTS];
    logic [2*CW-1:0] smem [SD];

    scan_state_t state_reg, state_next;

    logic [CNTW-1:0]      drain_cnt_reg, drain_cnt_next;
    logic [CNTW-1:0]      n_reg, n_next;
    logic [2*CW-1:0]      last_reg, last_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 upper_reg, upper_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        lower_len_reg, lower_len_next;
    logic [KW-1:0]        out_n_reg, out_n_next;
    logic                 single_reg, single_next;
    logic [SAW-1:0]       j_reg, j_next;
    logic [2*CW-1:0]      top_reg, top_next, sec_reg, sec_next, c_reg, c_next;
    logic signed [CW:0]   dx1_reg, dx1_next, dy2_reg, dy2_next;
    logic signed [CW:0]   dy1_reg, dy1_next, dx2_reg, dx2_next;
    logic signed [PW-1:0] p_reg, p_next, q_reg, q_next;
    hull_res_t            hull_reg, hull_next;
    logic                 hull_valid_reg, hull_valid_next;

    logic                 p_we, s_we;
    logic [IW-1:0]        p_waddr, p_raddr;
    logic [SAW-1:0]       s_waddr, s_raddr;
    logic [2*CW-1:0]      p_wdata, prd_reg, srd_reg, head, odata;
    logic [KW-1:0]        k_m3, lim;
    logic                 push, phase_end, is_new;
    logic signed [CW-1:0] top_x, top_y, sec_x, sec_y, c_x, c_y;

    assign head  = {head_x, head_y};
    assign top_x = signed'(top_reg[2*CW-1:CW]);
    assign top_y = signed'(top_reg[CW-1:0]);
    assign sec_x = signed'(sec_reg[2*CW-1:CW]);
    assign sec_y = signed'(sec_reg[CW-1:0]);
    assign c_x   = signed'(c_reg[2*CW-1:CW]);
    assign c_y   = signed'(c_reg[CW-1:0]);
    assign k_m3  = k_reg - KW'(3);
    assign lim   = upper_reg ? lower_len_reg : '0;
    assign odata = single_reg ? prd_reg : srd_reg;

    assign phase_end = upper_reg ? (idx_reg == '0)
                                 : (CNTW'(idx_reg) == n_reg - CNTW'(1));

    always_comb
    begin
        state_next      = state_reg;
        drain_cnt_next  = drain_cnt_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        upper_next      = upper_reg;
        k_next          = k_reg;
        lower_len_next  = lower_len_reg;
        out_n_next      = out_n_reg;
        single_next     = single_reg;
        j_next          = j_reg;
        top_next        = top_reg;
        sec_next        = sec_reg;
        c_next          = c_reg;
        dx1_next        = dx1_reg;
        dy2_next        = dy2_reg;
        dy1_next        = dy1_reg;
        dx2_next        = dx2_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        hull_next       = hull_reg;
        hull_valid_next = hull_valid_reg;
        p_we            = 1'b0;
        p_waddr         = n_reg[IW-1:0];
        p_wdata         = head;
        p_raddr         = idx_reg;
        s_we            = 1'b0;
        s_waddr         = k_reg[SAW-1:0];
        s_raddr         = k_m3[SAW-1:0];
        drain           = 1'b0;
        done            = 1'b0;
        push            = 1'b0;
        is_new          = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    drain_cnt_next = '0;
                    n_next         = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain  = 1'b1;
                is_new = (drain_cnt_reg == '0) || (head != last_reg);
                if (is_new)
                begin
                    p_we      = 1'b1;
                    n_next    = n_reg + CNTW'(1);
                    last_next = head;
                end
                drain_cnt_next = drain_cnt_reg + CNTW'(1);
                if (drain_cnt_next == stored_cnt)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                idx_next   = '0;
                upper_next = 1'b0;
                k_next     = '0;
                j_next     = '0;
                if (n_reg <= CNTW'(1))
                begin
                    single_next = 1'b1;
                    out_n_next  = KW'(1);
                    state_next  = ST_ORD;
                end
                else
                begin
                    single_next = 1'b0;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CATCH;
            end
            ST_CATCH:
            begin
                c_next     = prd_reg;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if ({1'b0, k_reg} >= {1'b0, lim} + (KW+1)'(2))
                begin
                    dx1_next   = (CW+1)'(top_x) - (CW+1)'(sec_x);
                    dy2_next   = (CW+1)'(c_y) - (CW+1)'(sec_y);
                    dy1_next   = (CW+1)'(top_y) - (CW+1)'(sec_y);
                    dx2_next   = (CW+1)'(c_x) - (CW+1)'(sec_x);
                    state_next = ST_MUL;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            ST_MUL:
            begin
                p_next     = PW'(dx1_reg) * PW'(dy2_reg);
                q_next     = PW'(dy1_reg) * PW'(dx2_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (p_reg > q_reg)
                begin
                    push = 1'b1;
                end
                else
                begin
                    // Not a strict left turn: pop the top and refetch the
                    // entry below the new top as the new second.
                    k_next     = k_reg - KW'(1);
                    top_next   = sec_reg;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                sec_next   = srd_reg;
                state_next = ST_TEST;
            end
            ST_ORD:
            begin
                s_raddr    = j_reg;
                p_raddr    = '0;
                state_next = ST_OLOAD;
            end
            ST_OLOAD:
            begin
                hull_next.hull_x       = 32'(signed'(odata[2*CW-1:CW]));
                hull_next.hull_y       = 32'(signed'(odata[CW-1:0]));
                hull_next.hull_z       = lowest_z;
                hull_next.hull_kind    = single_reg ? KIND_POINT :
                                         ((out_n_reg == KW'(2)) ? KIND_LINE : KIND_RING);
                hull_next.capacity_hit = overflow;
                hull_next.run_end      = (KW'(j_reg) == out_n_reg - KW'(1));
                hull_valid_next        = 1'b1;
                state_next             = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!hull_stall)
                begin
                    hull_valid_next = 1'b0;
                    if (hull_reg.run_end)
                    begin
                        done       = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + SAW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (push)
        begin
            s_we = 1'b1;
            if (phase_end)
            begin
                // Push followed by dropping the last entry leaves the stack
                // tops and the depth as they were.
                if (!upper_reg)
                begin
                    lower_len_next = k_reg;
                    upper_next     = 1'b1;
                    state_next     = ST_FETCH;
                end
                else
                begin
                    out_n_next = k_reg;
                    j_next     = '0;
                    state_next = ST_ORD;
                end
            end
            else
            begin
                sec_next   = top_reg;
                top_next   = c_reg;
                k_next     = k_reg + KW'(1);
                idx_next   = upper_reg ? (idx_reg - IW'(1)) : (idx_reg + IW'(1));
                state_next = ST_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            hull_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hull_valid_reg <= hull_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_cnt_reg <= drain_cnt_next;
        n_reg         <= n_next;
        last_reg      <= last_next;
        idx_reg       <= idx_next;
        upper_reg     <= upper_next;
        k_reg         <= k_next;
        lower_len_reg <= lower_len_next;
        out_n_reg     <= out_n_next;
        single_reg    <= single_next;
        j_reg         <= j_next;
        top_reg       <= top_next;
        sec_reg       <= sec_next;
        c_reg         <= c_next;
        dx1_reg       <= dx1_next;
        dy2_reg       <= dy2_next;
        dy1_reg       <= dy1_next;
        dx2_reg       <= dx2_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        hull_reg      <= hull_next;
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        prd_reg <= pmem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_waddr] <= c_reg;
        end
        srd_reg <= smem[s_raddr];
    end

    assign busy       = (state_reg != ST_LOAD);
    assign hull_valid = hull_valid_reg;
    assign hull       = hull_reg;

endmodule

// ===== hdl/convex_hull_2d.sv =====
// ----------------------------------------------------------------------------
// convex_hull_2d
// Planar convex hull of a point set, emitted counterclockwise.
// ----------------------------------------------------------------------------
// Points arrive one request per cycle on the point channel while the block is
// not busy, the last point of a set marked by set_end. Each point that fits
// is inserted into a row of sorting cells in the cycle it is accepted. After
// the last point the block stalls the point channel: the cells shift out in
// order while exact duplicates are removed, then a sequencer runs the
// monotone chain over the sorted points, once for the lower chain and once
// for the upper chain. In each pass a point is fetched from the point memory
// and then either pushed directly or put through an orientation test (the
// test state, the registered multipliers and the decide state), and every
// pop refetches the stack before the next test. Every hull vertex is then
// read, loaded into the output register and held until the hull channel
// takes it; the next vertex is read only after that. Every vertex carries
// the lowest z of the set; capacity_hit reports points dropped because more
// than MAX_POINTS arrived. Coordinates use the low COORD_BITS bits (at most
// 32) of each field, sign extended.
// ----------------------------------------------------------------------------
module convex_hull_2d
    import chull_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    output logic       point_stall,
    input  point_req_t point,
    output logic       hull_valid,
    input  logic       hull_stall,
    output hull_res_t  hull
);

    localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    // Per-set bookkeeping: how many points are held, the lowest z seen and
    // whether any point found the store full.
    logic [CNTW-1:0]    count_reg, count_next;
    logic signed [31:0] lowest_z_reg, lowest_z_next;
    logic               ovf_reg, ovf_next;

    logic               accept, start, busy, done, room;
    logic               chain_drain;
    logic signed [31:0] z_ext;
    logic signed [CW-1:0] new_x, new_y, head_x, head_y;
    chain_ctl_t         ctl;

    assign accept = point_valid && !point_stall;
    assign start  = accept && point.set_end;
    assign room   = (count_reg < CNTW'(MAX_POINTS));

    // Only the low coordinate bits take part; z is compared after sign
    // extension back to the full field width.
    assign new_x = signed'(point.pos_x[CW-1:0]);
    assign new_y = signed'(point.pos_y[CW-1:0]);
    assign z_ext = 32'(signed'(point.pos_z[CW-1:0]));

    always_comb
    begin
        count_next    = count_reg;
        lowest_z_next = lowest_z_reg;
        ovf_next      = ovf_reg;
        if (done)
        begin
            count_next    = '0;
            lowest_z_next = 32'sh7FFF_FFFF;
            ovf_next      = 1'b0;
        end
        else if (accept)
        begin
            if (z_ext < lowest_z_reg)
            begin
                lowest_z_next = z_ext;
            end
            if (room)
            begin
                count_next = count_reg + CNTW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            lowest_z_reg <= 32'sh7FFF_FFFF;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            lowest_z_reg <= lowest_z_next;
            ovf_reg      <= ovf_next;
        end
    end

    // The chain inserts while loading and shifts toward the head while the
    // scan drains it.
    assign ctl = '{ins: accept && room, drain: chain_drain};

    chull_chain #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .new_x  (new_x),
        .new_y  (new_y),
        .head_x (head_x),
        .head_y (head_y)
    );

    chull_scan #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .stored_cnt (count_reg),
        .lowest_z   (lowest_z_reg),
        .overflow   (ovf_reg),
        .head_x     (head_x),
        .head_y     (head_y),
        .drain      (chain_drain),
        .busy       (busy),
        .done       (done),
        .hull_valid (hull_valid),
        .hull_stall (hull_stall),
        .hull       (hull)
    );

    // No new point is taken until every vertex of the current set has left.
    assign point_stall = busy;

endmodule

// ===== hdl/chull_checker.sv =====
// ----------------------------------------------------------------------------
// chull_checker
// Port-level checks of the convex hull block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chull_checker
    import chull_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       point_valid,
    input logic       point_stall,
    input point_req_t point,
    input logic       hull_valid,
    input logic       hull_stall,
    input hull_res_t  hull
);

    // A stalled hull vertex stays and does not change.
    `CH_ASSERT_NEXT(a_hull_hold, hull_valid && hull_stall, hull_valid && $stable(hull))

    // Once the last point of a set is taken, loading stops.
    `CH_ASSERT_NEXT(a_end_stalls, point_valid && !point_stall && point.set_end, point_stall)

    // Vertices only appear while the point channel is held off.
    `CH_ASSERT_SAME(a_emit_busy, hull_valid, point_stall)

    // A vertex that is not the last of its run keeps the block busy.
    `CH_ASSERT_NEXT(a_run_open, hull_valid && !hull_stall && !hull.run_end, point_stall)

endmodule

bind convex_hull_2d chull_checker u_chull_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .hull_valid  (hull_valid),
    .hull_stall  (hull_stall),
    .hull        (hull)
);

// ===== verif/convex_hull_2d_tb.sv =====
// ----------------------------------------------------------------------------
// convex_hull_2d_tb
// Self-checking bench for the planar convex hull block.
// ----------------------------------------------------------------------------
// Point sets are sent as requests on the point channel. A behavioral hull
// predictor turns each finished set into the vertices it expects: sort by x
// then y, remove duplicates, monotone chain without collinear points. A
// monitor compares every accepted hull vertex with the oldest expected one.
// The sender idles in bursts and the receiver stalls on its own pattern,
// with one long hold-off so that the block backs up.
// ----------------------------------------------------------------------------
module convex_hull_2d_tb;
    import chull_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int IDLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       point_valid;
    logic       point_stall;
    point_req_t point;
    logic       hull_valid;
    logic       hull_stall;
    hull_res_t  hull;

    // State of the predictor for the set that is being collected.
    logic signed [31:0] set_x [NPTS];
    logic signed [31:0] set_y [NPTS];
    int                 set_count;
    logic signed [31:0] set_low_z;
    logic               set_dropped;

    hull_res_t expected_vertices[$];
    int        error_count;
    int        idle_cycles;
    bit        hold_off;
    bit        busy_sender;

    convex_hull_2d DUT (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point(point),
        .hull_valid(hull_valid),
        .hull_stall(hull_stall),
        .hull(hull)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Strict left turn of c relative to the directed line a to b.
    function automatic bit left_turn(input logic signed [31:0] ax, input logic signed [31:0] ay,
                                     input logic signed [31:0] bx, input logic signed [31:0] by,
                                     input logic signed [31:0] cx, input logic signed [31:0] cy);
        logic signed [33:0]  ux, uy, vx, vy;
        logic signed [69:0]  cross_prod;
        ux = bx - ax;
        uy = by - ay;
        vx = cx - ax;
        vy = cy - ay;
        cross_prod = ux * vy - uy * vx;
        return cross_prod > 0;
    endfunction

    function automatic bit xy_less(input logic signed [31:0] ax, input logic signed [31:0] ay,
                                   input logic signed [31:0] bx, input logic signed [31:0] by);
        if (ax != bx)
        begin
            return ax < bx;
        end
        return ay < by;
    endfunction

    // Folds one point into the current set; on the last point the hull of
    // the set is queued as a list of expected vertices.
    task automatic predict_hull(input point_req_t p);
        logic signed [31:0] sx [NPTS];
        logic signed [31:0] sy [NPTS];
        logic signed [31:0] tx, ty;
        int                 stack [2*NPTS+2];
        int                 n, m, i, j, k, lower_len, out_n;
        hull_kind_t         kind;
        hull_res_t          v;
        if (p.pos_z < set_low_z)
        begin
            set_low_z = p.pos_z;
        end
        if (set_count < NPTS)
        begin
            set_x[set_count] = p.pos_x;
            set_y[set_count] = p.pos_y;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (!p.set_end)
        begin
            return;
        end
        n = set_count;
        for (i = 0; i < n; i++)
        begin
            sx[i] = set_x[i];
            sy[i] = set_y[i];
        end
        for (i = 1; i < n; i++)
        begin
            tx = sx[i];
            ty = sy[i];
            j = i;
            while (j > 0 && xy_less(tx, ty, sx[j-1], sy[j-1]))
            begin
                sx[j] = sx[j-1];
                sy[j] = sy[j-1];
                j--;
            end
            sx[j] = tx;
            sy[j] = ty;
        end
        m = 0;
        for (i = 0; i < n; i++)
        begin
            if (m == 0 || sx[i] != sx[m-1] || sy[i] != sy[m-1])
            begin
                sx[m] = sx[i];
                sy[m] = sy[i];
                m++;
            end
        end
        if (m <= 1)
        begin
            out_n = 1;
            stack[0] = 0;
            kind = KIND_POINT;
        end
        else
        begin
            k = 0;
            for (i = 0; i < m; i++)
            begin
                while (k >= 2 && !left_turn(sx[stack[k-2]], sy[stack[k-2]],
                                            sx[stack[k-1]], sy[stack[k-1]], sx[i], sy[i]))
                begin
                    k--;
                end
                stack[k++] = i;
            end
            k--;
            lower_len = k;
            for (i = m - 1; i >= 0; i--)
            begin
                while (k >= lower_len + 2 &&
                       !left_turn(sx[stack[k-2]], sy[stack[k-2]],
                                  sx[stack[k-1]], sy[stack[k-1]], sx[i], sy[i]))
                begin
                    k--;
                end
                stack[k++] = i;
            end
            k--;
            out_n = k;
            kind = (out_n == 2) ? KIND_LINE : KIND_RING;
        end
        for (i = 0; i < out_n; i++)
        begin
            v.hull_x = sx[stack[i]];
            v.hull_y = sy[stack[i]];
            v.hull_z = set_low_z;
            v.hull_kind = kind;
            v.capacity_hit = set_dropped;
            v.run_end = (i + 1 == out_n);
            expected_vertices = {expected_vertices, v};
        end
        set_count = 0;
        set_low_z = 32'sh7FFFFFFF;
        set_dropped = 1'b0;
    endtask

    // Offers one request, holds it until accepted, then maybe idles.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input bit last);
        point_req_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.set_end = last;
        point <= p;
        point_valid <= 1'b1;
        @(posedge clk);
        while (point_stall)
        begin
            @(posedge clk);
        end
        predict_hull(p);
        // Bursts: a gap is taken only when the current burst runs out.
        if (!busy_sender || $urandom_range(0, 5) == 0)
        begin
            busy_sender = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                point_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom_range(0, 15) - 8;
            1: return $signed($urandom());
            default: return ($urandom_range(0, 200) - 100) <<< 16;
        endcase
    endfunction

    // Monitor: every accepted vertex is compared with the oldest expected one.
    always @(posedge clk)
    begin
        hull_res_t want;
        if (rst_n && hull_valid && !hull_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("hull vertex with none expected: %p", hull);
                error_count++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (hull.hull_x !== want.hull_x)
                begin
                    $error("hull_x expected %0d actual %0d", want.hull_x, hull.hull_x);
                    error_count++;
                end
                if (hull.hull_y !== want.hull_y)
                begin
                    $error("hull_y expected %0d actual %0d", want.hull_y, hull.hull_y);
                    error_count++;
                end
                if (hull.hull_z !== want.hull_z)
                begin
                    $error("hull_z expected %0d actual %0d", want.hull_z, hull.hull_z);
                    error_count++;
                end
                if (hull.hull_kind !== want.hull_kind)
                begin
                    $error("hull_kind expected %0d actual %0d", want.hull_kind, hull.hull_kind);
                    error_count++;
                end
                if (hull.capacity_hit !== want.capacity_hit)
                begin
                    $error("capacity_hit expected %0b actual %0b",
                           want.capacity_hit, hull.capacity_hit);
                    error_count++;
                end
                if (hull.run_end !== want.run_end)
                begin
                    $error("run_end expected %0b actual %0b", want.run_end, hull.run_end);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hull_stall <= 1'b0;
        end
        else if (hold_off)
        begin
            hull_stall <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: hull_stall <= ($urandom_range(0, 1) == 0);
                1: hull_stall <= 1'b0;
                default: hull_stall <= hull_stall;
            endcase
        end
    end

    // Long hold-off counted in its own process.
    task automatic run_hold_off();
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    endtask

    // Watchdog on cycles without any accepted request or vertex.
    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (hull_valid && !hull_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Corners: extremes of each field, a single point, duplicates only,
    // collinear points, a square with interior points.
    task automatic test_directed();
        send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
        send_point(5, 5, 1, 1'b0);
        send_point(5, 5, -1, 1'b1);
        send_point(32'sh80000000, 32'sh80000000, 0, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        send_point(0, 0, 3, 1'b0);
        send_point(2, 2, 3, 1'b0);
        send_point(1, 1, 3, 1'b0);
        send_point(3, 3, 3, 1'b1);
        send_point(0, 0, 0, 1'b0);
        send_point(10, 0, 0, 1'b0);
        send_point(10, 10, 0, 1'b0);
        send_point(0, 10, 0, 1'b0);
        send_point(5, 5, -7, 1'b0);
        send_point(5, 0, 0, 1'b0);
        send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 2, 1'b1);
    endtask

    // One set past capacity, with the lowest z among the dropped points.
    task automatic test_capacity();
        int i;
        for (i = 0; i < NPTS + 6; i++)
        begin
            send_point(rand_coord(0), rand_coord(0), (i > NPTS) ? -500 : i, i == NPTS + 5);
        end
    endtask

    // Random sets of random size and coordinate style.
    task automatic test_random(input int budget);
        int sent, size, mode, i;
        sent = 0;
        while (sent < budget)
        begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            mode = $urandom_range(0, 2);
            for (i = 0; i < size; i++)
            begin
                send_point(rand_coord(mode), rand_coord(mode), $signed($urandom()),
                           i == size - 1);
            end
            sent += size;
        end
    endtask

    // Long receiver hold-off while sets keep arriving.
    task automatic test_backpressure();
        fork
            run_hold_off();
            test_random(20);
        join
    endtask

    initial
    begin
        int tail;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        hold_off = 1'b0;
        busy_sender = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        set_count = 0;
        set_low_z = 32'sh7FFFFFFF;
        set_dropped = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random(25);
        point_valid <= 1'b0;
        while (expected_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        tail = 0;
        while (tail < 200)
        begin
            @(posedge clk);
            tail++;
        end
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/chull_pkg.sv
hdl/chull_cell.sv
hdl/chull_chain.sv
hdl/chull_scan.sv
hdl/convex_hull_2d.sv
hdl/chull_checker.sv
verif/convex_hull_2d_tb.sv
